FILE: src/lcmlt_pkg.sv
// shared types and constants for the li chao minimum line tree
package lcmlt_pkg;

  // operation codes of the input word
  localparam logic [1:0] OP_LINE   = 2'd0;
  localparam logic [1:0] OP_SEG    = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // register indexes on the configuration port
  localparam logic [1:0] REG_X_MIN     = 2'd0;
  localparam logic [1:0] REG_X_MAX     = 2'd1;
  localparam logic [1:0] REG_LEAF_CNT  = 2'd2;
  localparam logic [1:0] REG_EMPTY_ICP = 2'd3;

  // node word: valid, slope, intercept
  localparam int LINE_W = 97;
  // offset coordinates: 32-bit x plus a tree position
  localparam int XW = 34;
  // evaluations per descent step: two lines at three points
  localparam logic [2:0] EV_LAST = 3'd5;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALIGN,
    ST_READ,
    ST_LOAD,
    ST_EV_MUL,
    ST_EV_ADD,
    ST_DEC,
    ST_SEG_L,
    ST_SEG_R,
    ST_SEG_SHIFT,
    ST_Q_MUL,
    ST_Q_ADD,
    ST_Q_OUT
  } state_t;

endpackage

FILE: src/lcmlt_ram.sv
// generic single-port-write, single-port-read ram with registered read
module lcmlt_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                         wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/li_chao_min_line_tree_top.sv
// li chao tree with minimum query: node memory plus read-modify-write sequencer
// query: reads, loads, multiplies and adds at each tree level (log2(leaves)+1 levels),
//   then outputs the word; full line insert first aligns the node to leaf scale, then at
//   each descent level reads, loads, evaluates two lines at three points and decides
// throughput: one word at a time; segment insert runs one descent per canonical node
// reset: synchronous; afterwards a clearing pass writes every node invalid while the
//   input side stalls, configuration is taken as ever
module li_chao_min_line_tree_top #(
  parameter int MAX_LEAVES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  // input word
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic signed [31:0] slope,
  input  logic signed [63:0] intercept,
  input  logic signed [31:0] seg_left,
  input  logic signed [31:0] seg_right,
  input  logic signed [31:0] query_x,
  // result word
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] min_value
);

  localparam int NODE_DEPTH = 2 * MAX_LEAVES;
  localparam int NW  = $clog2(NODE_DEPTH);
  localparam int LW  = $clog2(MAX_LEAVES) + 1;
  localparam int SGW = NW + 1;
  localparam int XW  = lcmlt_pkg::XW;
  localparam int LNW = lcmlt_pkg::LINE_W;

  // configuration registers
  logic signed [31:0] x_min;
  logic signed [31:0] x_max;
  logic [10:0]        leaf_count;
  logic signed [63:0] empty_intercept;

  lcmlt_pkg::state_t state, state_next, ret;

  logic [NW-1:0]  clr;
  logic [NW-1:0]  idx;
  logic [NW-1:0]  t;          // node index scaled up to leaf level
  logic [LW-1:0]  sp;         // node span in leaves
  logic [LW-1:0]  left, right;
  logic [SGW-1:0] l, r;       // canonical split bounds
  logic [2:0]     e;
  logic           qmode;

  logic signed [31:0] ln_k, cur_k, qx;
  logic signed [63:0] ln_c, cur_c, best, prod;
  logic signed [31:0] xlo, xhi, xmid;
  logic signed [XW-1:0] pos;
  logic signed [63:0] vals [6];

  // memory ports
  logic           ram_we;
  logic [NW-1:0]  ram_waddr;
  logic [LNW-1:0] ram_wdata, ram_rdata;

  lcmlt_ram #(.W(LNW), .D(NODE_DEPTH)) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  function automatic logic signed [31:0] clip_x(input logic signed [XW-1:0] v,
                                                input logic signed [31:0] xm);
    clip_x = (v < XW'(xm)) ? v[31:0] : xm;
  endfunction

  // effective tree size: clamp then round down to a power of two
  logic [LW-1:0] clamp, size;
  always_comb begin
    if (leaf_count == 11'd0) begin
      clamp = LW'(1);
    end else if (32'(leaf_count) > MAX_LEAVES) begin
      clamp = LW'(MAX_LEAVES);
    end else begin
      clamp = LW'(leaf_count);
    end
    size = '0;
    for (int i = 0; i < LW; i++) begin
      if (clamp[i]) begin
        size    = '0;
        size[i] = 1'b1;
      end
    end
  end

  // segment bounds relative to the tree, clamped to its leaves
  logic signed [XW-1:0] xmin_e, size_s, seg_lo, seg_hi, lo_c, hi_c;
  logic                 seg_empty;
  logic [SGW-1:0]       l_init, r_init;
  always_comb begin
    xmin_e    = XW'(x_min);
    size_s    = $signed(XW'(size));
    seg_lo    = XW'(seg_left) - xmin_e;
    seg_hi    = XW'(seg_right) - xmin_e;
    lo_c      = (seg_lo < 0) ? '0 : seg_lo;
    hi_c      = (seg_hi > size_s - 1) ? size_s - 1 : seg_hi;
    seg_empty = lo_c > hi_c;
    l_init    = SGW'(lo_c[LW-1:0]) + SGW'(size);
    r_init    = SGW'(hi_c[LW-1:0]) + SGW'(size) + SGW'(1);
  end

  // midpoint and per-step decisions
  logic [LW:0]   mid_sum;
  logic [LW-1:0] mid;
  logic          lo_b, hi_b, mo_b, at_leaf, go_left_q, align_done;
  logic signed [63:0] qv;
  logic [LW-1:0] align_left;
  logic [SGW-1:0] r_dec;
  always_comb begin
    mid_sum    = (LW+1)'(left) + (LW+1)'(right);
    mid        = mid_sum[LW:1];
    lo_b       = vals[0] < vals[1];
    hi_b       = vals[2] < vals[3];
    mo_b       = vals[4] < vals[5];
    qv         = prod + cur_c;
    at_leaf    = ((LW+1)'(left) + (LW+1)'(1)) >= (LW+1)'(right);
    go_left_q  = pos < $signed(XW'(mid));
    align_done = SGW'(t) >= SGW'(size);
    align_left = LW'(SGW'(t) - SGW'(size));
    r_dec      = r - SGW'(1);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lcmlt_pkg::ST_CLEAR: begin
        if (clr == NW'(NODE_DEPTH - 1)) state_next = lcmlt_pkg::ST_IDLE;
      end
      lcmlt_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (op)
            lcmlt_pkg::OP_LINE:  state_next = lcmlt_pkg::ST_ALIGN;
            lcmlt_pkg::OP_SEG:   state_next = seg_empty ? lcmlt_pkg::ST_IDLE
                                                        : lcmlt_pkg::ST_SEG_L;
            lcmlt_pkg::OP_QUERY: state_next = lcmlt_pkg::ST_READ;
            default:             state_next = lcmlt_pkg::ST_IDLE;
          endcase
        end
      end
      lcmlt_pkg::ST_ALIGN:  if (align_done) state_next = lcmlt_pkg::ST_READ;
      lcmlt_pkg::ST_READ:   state_next = lcmlt_pkg::ST_LOAD;
      lcmlt_pkg::ST_LOAD: begin
        state_next = qmode ? lcmlt_pkg::ST_Q_MUL : lcmlt_pkg::ST_EV_MUL;
      end
      lcmlt_pkg::ST_EV_MUL: state_next = lcmlt_pkg::ST_EV_ADD;
      lcmlt_pkg::ST_EV_ADD: begin
        state_next = (e == lcmlt_pkg::EV_LAST) ? lcmlt_pkg::ST_DEC : lcmlt_pkg::ST_EV_MUL;
      end
      lcmlt_pkg::ST_DEC:    state_next = (lo_b == hi_b) ? ret : lcmlt_pkg::ST_READ;
      lcmlt_pkg::ST_SEG_L: begin
        if (!(l < r))  state_next = lcmlt_pkg::ST_IDLE;
        else if (l[0]) state_next = lcmlt_pkg::ST_ALIGN;
        else           state_next = lcmlt_pkg::ST_SEG_R;
      end
      lcmlt_pkg::ST_SEG_R: begin
        state_next = r[0] ? lcmlt_pkg::ST_ALIGN : lcmlt_pkg::ST_SEG_SHIFT;
      end
      lcmlt_pkg::ST_SEG_SHIFT: state_next = lcmlt_pkg::ST_SEG_L;
      lcmlt_pkg::ST_Q_MUL:     state_next = lcmlt_pkg::ST_Q_ADD;
      lcmlt_pkg::ST_Q_ADD: begin
        state_next = at_leaf ? lcmlt_pkg::ST_Q_OUT : lcmlt_pkg::ST_READ;
      end
      lcmlt_pkg::ST_Q_OUT: begin
        if (!out_valid || !out_stall) state_next = lcmlt_pkg::ST_IDLE;
      end
      default: state_next = lcmlt_pkg::ST_IDLE;
    endcase
  end

  // outputs and memory controls
  logic signed [31:0] mk, mx;
  logic signed [63:0] mc;
  always_comb begin
    in_stall  = (state != lcmlt_pkg::ST_IDLE);
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = {1'b1, ln_k, ln_c};
    mk        = e[0] ? cur_k : ln_k;
    mc        = e[0] ? cur_c : ln_c;
    case (e[2:1])
      2'd0:    mx = xlo;
      2'd1:    mx = xhi;
      default: mx = xmid;
    endcase
    case (state)
      lcmlt_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr;
        ram_wdata = '0;
      end
      lcmlt_pkg::ST_DEC: begin
        // new line wins on the whole node, or wins at the middle
        ram_we = (lo_b == hi_b) ? lo_b : mo_b;
      end
      lcmlt_pkg::ST_Q_MUL: begin
        mk = cur_k;
        mx = qx;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= lcmlt_pkg::ST_CLEAR;
      clr             <= '0;
      out_valid       <= 1'b0;
      x_min           <= 32'sd0;
      x_max           <= 32'sd1023;
      leaf_count      <= 11'd1024;
      empty_intercept <= 64'sh4000000000000000;
    end else begin
      state <= state_next;
      if (state == lcmlt_pkg::ST_CLEAR) clr <= clr + NW'(1);
      if (state == lcmlt_pkg::ST_Q_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          lcmlt_pkg::REG_X_MIN:     x_min           <= pwdata[31:0];
          lcmlt_pkg::REG_X_MAX:     x_max           <= pwdata[31:0];
          lcmlt_pkg::REG_LEAF_CNT:  leaf_count      <= pwdata[10:0];
          lcmlt_pkg::REG_EMPTY_ICP: empty_intercept <= pwdata;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      lcmlt_pkg::ST_IDLE: begin
        ln_k  <= slope;
        ln_c  <= intercept;
        qx    <= query_x;
        pos   <= XW'(query_x) - xmin_e;
        qmode <= (op == lcmlt_pkg::OP_QUERY);
        idx   <= NW'(1);
        t     <= NW'(1);
        sp    <= LW'(1);
        left  <= '0;
        right <= size;
        best  <= empty_intercept;
        ret   <= lcmlt_pkg::ST_IDLE;
        l     <= l_init;
        r     <= r_init;
      end
      lcmlt_pkg::ST_ALIGN: begin
        // walk the node down to leaf scale to get its leaf range
        if (!align_done) begin
          t  <= t << 1;
          sp <= sp << 1;
        end else begin
          left  <= align_left;
          right <= align_left + sp;
        end
      end
      lcmlt_pkg::ST_LOAD: begin
        cur_k <= ram_rdata[LNW-1] ? ram_rdata[95:64] : 32'sd0;
        cur_c <= ram_rdata[LNW-1] ? ram_rdata[63:0] : empty_intercept;
        xlo   <= clip_x($signed(XW'(left)) + xmin_e, x_max);
        xhi   <= clip_x($signed(XW'(LW'(right - LW'(1)))) + xmin_e, x_max);
        xmid  <= clip_x($signed(XW'(mid)) + xmin_e, x_max);
        e     <= '0;
      end
      lcmlt_pkg::ST_EV_MUL: prod <= mk * mx;
      lcmlt_pkg::ST_EV_ADD: begin
        vals[e] <= prod + mc;
        e       <= e + 3'd1;
      end
      lcmlt_pkg::ST_DEC: begin
        if (lo_b != hi_b) begin
          if (mo_b) begin
            ln_k <= cur_k;
            ln_c <= cur_c;
          end
          if (lo_b != mo_b) begin
            idx   <= idx << 1;
            right <= mid;
          end else begin
            idx  <= (idx << 1) | NW'(1);
            left <= mid;
          end
        end
      end
      lcmlt_pkg::ST_SEG_L: begin
        if ((l < r) && l[0]) begin
          idx <= l[NW-1:0];
          t   <= l[NW-1:0];
          sp  <= LW'(1);
          l   <= l + SGW'(1);
          ret <= lcmlt_pkg::ST_SEG_R;
        end
      end
      lcmlt_pkg::ST_SEG_R: begin
        if (r[0]) begin
          idx <= r_dec[NW-1:0];
          t   <= r_dec[NW-1:0];
          sp  <= LW'(1);
          r   <= r_dec;
          ret <= lcmlt_pkg::ST_SEG_SHIFT;
        end
      end
      lcmlt_pkg::ST_SEG_SHIFT: begin
        l <= l >> 1;
        r <= r >> 1;
      end
      lcmlt_pkg::ST_Q_MUL: prod <= mk * mx;
      lcmlt_pkg::ST_Q_ADD: begin
        if (qv < best) best <= qv;
        if (!at_leaf) begin
          if (go_left_q) begin
            idx   <= idx << 1;
            right <= mid;
          end else begin
            idx  <= (idx << 1) | NW'(1);
            left <= mid;
          end
        end
      end
      lcmlt_pkg::ST_Q_OUT: begin
        if (!out_valid || !out_stall) min_value <= best;
      end
      default: ;
    endcase
  end

  // register readback
  assign pready = 1'b1;
  always_comb begin
    case (paddr[4:3])
      lcmlt_pkg::REG_X_MIN:    prdata = 64'(x_min);
      lcmlt_pkg::REG_X_MAX:    prdata = 64'(x_max);
      lcmlt_pkg::REG_LEAF_CNT: prdata = 64'(leaf_count);
      default:                 prdata = empty_intercept;
    endcase
  end

endmodule

FILE: src/lcmlt_checker.sv
// port-level checks for the li chao minimum line tree, bound to the top level
module lcmlt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  op,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] min_value
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(min_value))
    else $error("stalled result word changed");

  // clearing pass blocks input right after reset
  a_clear_stall: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input not stalled during clearing pass");

  // a query keeps the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == lcmlt_pkg::OP_QUERY |=> in_stall)
    else $error("query accepted without walking the tree");

  // a result only appears at the end of busy work
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word without a query in progress");

endmodule

bind li_chao_min_line_tree_top lcmlt_checker u_chk (.*);
